>>> sv/hyphen_split_checker_top_defines.svh
// Assertion macros for the hyphen split checker
`ifndef HYPHEN_SPLIT_CHECKER_TOP_DEFINES_SVH
`define HYPHEN_SPLIT_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hsc_pkg.sv
`default_nettype none
package hsc_pkg;

  localparam int MAX_WORD = 64;
  localparam int ROW_BITS = 16;
  localparam int POS_W    = $clog2(MAX_WORD + 1);

  typedef logic [7:0]       char_t;
  typedef logic [5:0]       split_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [1:0]       cnt_t;
  typedef logic [3:0]       sfx_t;
  typedef logic [ROW_BITS-1:0] row_t;

  localparam sfx_t SFX_IDLE = 4'd0;
  localparam sfx_t SFX_I    = 4'd1;
  localparam sfx_t SFX_IN   = 4'd2;
  localparam sfx_t SFX_ING  = 4'd3;
  localparam sfx_t SFX_T    = 4'd4;
  localparam sfx_t SFX_TI   = 4'd5;
  localparam sfx_t SFX_TIO  = 4'd6;
  localparam sfx_t SFX_TION = 4'd7;
  localparam sfx_t SFX_FAIL = 4'd8;

  localparam logic [0:0] REG_HALF_FWD = 1'b0;
  localparam logic [0:0] REG_HALF_REV = 1'b1;

  localparam cnt_t LETTERS_MIN = 2'd3;

  function automatic char_t to_lower(input char_t c);
    to_lower = (c >= "A" && c <= "Z") ? char_t'(c + 8'd32) : c;
  endfunction

  function automatic logic is_letter(input char_t c);
    char_t l;
    l = to_lower(c);
    is_letter = (l >= "a") && (l <= "z");
  endfunction

  function automatic logic is_vowel(input char_t c);
    char_t l;
    l = to_lower(c);
    is_vowel = (l == "e") || (l == "a") || (l == "o") || (l == "i") ||
               (l == "u") || (l == "y");
  endfunction

  function automatic sfx_t suffix_next(input sfx_t s, input char_t c);
    char_t l;
    l = to_lower(c);
    case (s)
      SFX_IDLE: suffix_next = (l == "i") ? SFX_I : ((l == "t") ? SFX_T : SFX_FAIL);
      SFX_I:    suffix_next = (l == "n") ? SFX_IN : SFX_FAIL;
      SFX_IN:   suffix_next = (l == "g") ? SFX_ING : SFX_FAIL;
      SFX_T:    suffix_next = (l == "i") ? SFX_TI : SFX_FAIL;
      SFX_TI:   suffix_next = (l == "o") ? SFX_TIO : SFX_FAIL;
      SFX_TIO:  suffix_next = (l == "n") ? SFX_TION : SFX_FAIL;
      default:  suffix_next = SFX_FAIL;
    endcase
  endfunction

  // row 0: right letter a..p, row 1: right letter q..z; col: left letter
  function automatic row_t pair_row(input logic row, input logic [4:0] col);
    row_t r0;
    row_t r1;
    case (col)
      5'd0:  begin r0 = 16'o000000; r1 = 16'o000000; end
      5'd1:  begin r0 = 16'o073555; r1 = 16'o133500; end
      5'd2:  begin r0 = 16'o073155; r1 = 16'o133500; end
      5'd3:  begin r0 = 16'o072575; r1 = 16'o133500; end
      5'd4:  begin r0 = 16'o000000; r1 = 16'o000000; end
      5'd5:  begin r0 = 16'o071555; r1 = 16'o123500; end
      5'd6:  begin r0 = 16'o073171; r1 = 16'o133500; end
      5'd7:  begin r0 = 16'o073575; r1 = 16'o173500; end
      5'd8:  begin r0 = 16'o000000; r1 = 16'o000000; end
      5'd9:  begin r0 = 16'o073575; r1 = 16'o173500; end
      5'd10: begin r0 = 16'o073575; r1 = 16'o173500; end
      5'd11: begin r0 = 16'o073575; r1 = 16'o171500; end
      5'd12: begin r0 = 16'o073575; r1 = 16'o173500; end
      5'd13: begin r0 = 16'o052565; r1 = 16'o143500; end
      5'd14: begin r0 = 16'o000000; r1 = 16'o000000; end
      5'd15: begin r0 = 16'o073155; r1 = 16'o133500; end
      5'd16: begin r0 = 16'o073575; r1 = 16'o173500; end
      5'd17: begin r0 = 16'o073524; r1 = 16'o123500; end
      5'd18: begin r0 = 16'o053114; r1 = 16'o161500; end
      5'd19: begin r0 = 16'o053175; r1 = 16'o112500; end
      5'd20: begin r0 = 16'o000000; r1 = 16'o000000; end
      5'd21: begin r0 = 16'o073575; r1 = 16'o173500; end
      5'd22: begin r0 = 16'o073155; r1 = 16'o133500; end
      5'd23: begin r0 = 16'o073575; r1 = 16'o173500; end
      5'd24: begin r0 = 16'o000000; r1 = 16'o000000; end
      5'd25: begin r0 = 16'o073575; r1 = 16'o173500; end
      default: begin r0 = '0; r1 = '0; end
    endcase
    pair_row = row ? r1 : r0;
  endfunction

endpackage
`default_nettype wire

>>> sv/hyphen_split_checker_top.sv
// Channel | Ports                                  | Dir | Notes
// in      | in_valid in_ready in_ch in_split_pos in_last | in  | one char per transfer
// out     | out_valid out_ready out_divisible      | out | one word per input word
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | in  | always ready
//
// One character per cycle while the output register is free or being read; a result
// appears in the cycle after the last character is taken, from the output register.
// Input is held off only while a result sits in the output register unread.
// rst_n is synchronous, active low; it clears word state and both markers.
`default_nettype none
`include "hyphen_split_checker_top_defines.svh"
module hyphen_split_checker_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire hsc_pkg::char_t  in_ch,
  input  wire hsc_pkg::split_t in_split_pos,
  input  wire logic            in_last,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_divisible,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire hsc_pkg::char_t  cfg_data
);
  import hsc_pkg::*;

  char_t half_fwd_r, half_rev_r;
  pos_t  char_pos_r, char_pos_nxt, pos_upd;
  cnt_t  left_cnt_r, left_cnt_nxt, left_upd;
  cnt_t  right_cnt_r, right_cnt_nxt, right_upd;
  logic  blocked_r, blocked_nxt, blocked_upd;
  logic  lvowel_r, lvowel_nxt, lvowel_upd;
  logic  rvowel_r, rvowel_nxt, rvowel_upd;
  char_t bprev_r, bprev_nxt;
  char_t prev_r, prev_nxt;
  char_t pair_l_r, pair_l_nxt, pair_l_upd;
  char_t pair_r_r, pair_r_nxt, pair_r_upd;
  logic  pair_eq_r, pair_eq_nxt, pair_eq_upd;
  sfx_t  sfx_r, sfx_nxt, sfx_upd;
  logic  out_valid_r, out_valid_nxt;
  logic  div_r, div_nxt;

  logic  in_acc, word_done;
  pos_t  sp;
  logic  letter, vowel, blocker;
  char_t lc, rc;
  logic [4:0] rc_idx;
  row_t  row;
  logic  decision;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign word_done = in_acc && in_last;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_divisible = div_r;

  always_comb begin
    sp      = pos_t'(in_split_pos);
    letter  = is_letter(in_ch);
    vowel   = is_vowel(in_ch);
    blocker = (in_ch == "-") || (in_ch == "/") || (in_ch == "_") ||
              (in_ch == "<") || (in_ch == ">") ||
              (in_ch == half_fwd_r) || (in_ch == half_rev_r);

    blocked_upd = blocked_r || blocker;
    left_upd    = left_cnt_r;
    right_upd   = right_cnt_r;
    if (letter) begin
      if (char_pos_r <= sp) begin
        if (left_cnt_r != LETTERS_MIN) left_upd = cnt_t'(left_cnt_r + 2'd1);
      end else begin
        if (right_cnt_r != LETTERS_MIN) right_upd = cnt_t'(right_cnt_r + 2'd1);
      end
    end
    lvowel_upd = lvowel_r || (vowel && (char_pos_r < sp));
    rvowel_upd = rvowel_r || (vowel && !(char_pos_r < sp));
    pair_l_upd  = pair_l_r;
    pair_r_upd  = pair_r_r;
    pair_eq_upd = pair_eq_r;
    if (char_pos_r == sp) begin
      pair_l_upd  = prev_r;
      pair_r_upd  = in_ch;
      pair_eq_upd = (bprev_r == prev_r);
    end
    sfx_upd = (char_pos_r >= sp) ? suffix_next(sfx_r, in_ch) : sfx_r;
    pos_upd = (char_pos_r < pos_t'(MAX_WORD)) ? pos_t'(char_pos_r + 1'b1) : char_pos_r;

    // verdict on the word as it stands after this character
    lc     = to_lower(pair_l_upd);
    rc     = to_lower(pair_r_upd);
    rc_idx = 5'(rc - "a");
    row    = pair_row(rc_idx[4], 5'(lc - "a"));
    if (blocked_upd || (left_upd != LETTERS_MIN) || (right_upd != LETTERS_MIN) ||
        !lvowel_upd || !rvowel_upd) begin
      decision = 1'b0;
    end else if (((sfx_upd == SFX_ING) || (sfx_upd == SFX_TION)) && !pair_eq_upd) begin
      decision = 1'b1;
    end else if (!is_letter(pair_l_upd) || !is_letter(pair_r_upd)) begin
      decision = 1'b0;
    end else begin
      decision = row[~rc_idx[3:0]];
    end
  end

  always_comb begin
    char_pos_nxt  = char_pos_r;
    left_cnt_nxt  = left_cnt_r;
    right_cnt_nxt = right_cnt_r;
    blocked_nxt   = blocked_r;
    lvowel_nxt    = lvowel_r;
    rvowel_nxt    = rvowel_r;
    bprev_nxt     = bprev_r;
    prev_nxt      = prev_r;
    pair_l_nxt    = pair_l_r;
    pair_r_nxt    = pair_r_r;
    pair_eq_nxt   = pair_eq_r;
    sfx_nxt       = sfx_r;
    if (word_done) begin
      char_pos_nxt  = '0;
      left_cnt_nxt  = '0;
      right_cnt_nxt = '0;
      blocked_nxt   = 1'b0;
      lvowel_nxt    = 1'b0;
      rvowel_nxt    = 1'b0;
      bprev_nxt     = '0;
      prev_nxt      = '0;
      pair_l_nxt    = '0;
      pair_r_nxt    = '0;
      pair_eq_nxt   = 1'b0;
      sfx_nxt       = SFX_IDLE;
    end else if (in_acc) begin
      char_pos_nxt  = pos_upd;
      left_cnt_nxt  = left_upd;
      right_cnt_nxt = right_upd;
      blocked_nxt   = blocked_upd;
      lvowel_nxt    = lvowel_upd;
      rvowel_nxt    = rvowel_upd;
      bprev_nxt     = prev_r;
      prev_nxt      = in_ch;
      pair_l_nxt    = pair_l_upd;
      pair_r_nxt    = pair_r_upd;
      pair_eq_nxt   = pair_eq_upd;
      sfx_nxt       = sfx_upd;
    end
    out_valid_nxt = word_done || (out_valid_r && !out_ready);
    div_nxt       = word_done ? decision : div_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_fwd_r  <= '0;
      half_rev_r  <= '0;
      char_pos_r  <= '0;
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      blocked_r   <= 1'b0;
      lvowel_r    <= 1'b0;
      rvowel_r    <= 1'b0;
      bprev_r     <= '0;
      prev_r      <= '0;
      pair_l_r    <= '0;
      pair_r_r    <= '0;
      pair_eq_r   <= 1'b0;
      sfx_r       <= SFX_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index[1] == 1'b0)) begin
        if (cfg_index[0] == REG_HALF_FWD) half_fwd_r <= cfg_data;
        if (cfg_index[0] == REG_HALF_REV) half_rev_r <= cfg_data;
      end
      char_pos_r  <= char_pos_nxt;
      left_cnt_r  <= left_cnt_nxt;
      right_cnt_r <= right_cnt_nxt;
      blocked_r   <= blocked_nxt;
      lvowel_r    <= lvowel_nxt;
      rvowel_r    <= rvowel_nxt;
      bprev_r     <= bprev_nxt;
      prev_r      <= prev_nxt;
      pair_l_r    <= pair_l_nxt;
      pair_r_r    <= pair_r_nxt;
      pair_eq_r   <= pair_eq_nxt;
      sfx_r       <= sfx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  `HSC_ASSERT_NEXT(a_last_gives_result, word_done, out_valid_r,
    "last char accepted but no result word")
  `HSC_ASSERT_NEXT(a_word_state_cleared, word_done,
    (char_pos_r == '0) && !blocked_r && (sfx_r == SFX_IDLE) && (left_cnt_r == '0),
    "word state not cleared after result")
  `HSC_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid_r && !out_ready,
    "input stalled without a pending result")
  `HSC_ASSERT_NOW(a_pos_bounded, 1'b1, char_pos_r <= pos_t'(MAX_WORD),
    "char position past word limit")
  `HSC_ASSERT_NOW(a_result_from_last, $rose(out_valid_r), $past(word_done),
    "result appeared without a last char")

endmodule
`default_nettype wire
